// ===== sv/rdsr_pkg.sv =====
// Package for the random-dot stereogram row engine.
// Holds register indexes, reset values and the request type of the separation unit.
// Used by the top level, the separation unit and the testbench; depends on nothing.
package rdsr_pkg;

    localparam int DEF_MAX_ROW_WIDTH = 1024;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FAR_SEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_RNG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEED      = 3'd5;

    // Reset values of the registers.
    localparam logic [10:0] RST_FAR_SEP   = 11'd64;
    localparam logic [10:0] RST_DEPTH_RNG = 11'd64;
    localparam logic [8:0]  RST_MAX_LEVEL = 9'd256;
    localparam logic [10:0] RST_ROW_WIDTH = 11'd1024;
    localparam logic [31:0] RST_SEED      = 32'd1;

    // Colour generator constants.
    localparam logic [31:0] LFSR_MASK   = 32'h8020_0003;
    localparam logic [8:0]  COLOUR_SPAN = 9'd255;

    // Signed separation width.
    localparam int SEP_W = 23;

    // Request to the separation unit.
    typedef struct packed {
        logic [10:0] far_sep;
        logic [10:0] depth_rng;
        logic [8:0]  max_c;
        logic        invert;
        logic [7:0]  depth;
    } t_sep_req;

endpackage

// ===== sv/random_dot_stereogram_row.sv =====
// Top level of the random-dot stereogram row engine: sequencer, link chain walk,
// colour generator and output register. Depends on rdsr_pkg, rdsr_ram, rdsr_sep_unit.
//
//  channel   dir  tdata                          tuser / tlast
//  s_axis    in   pixel_depth[7:0]               tuser: func
//  m_axis    out  pixel_x[9:0], colour[17:10]    tlast: row_done
//  cfg       in   i_cfg_idx selects, i_cfg_data  write on i_cfg_we
//
// A load first clears the link store when it is at column 0, then runs the separation
// divider, then walks the chain with a read and a check of each link visited through the
// single link memory port. An emit reads the link, picks a fresh or copied colour and hands it on.
// After reset and after each row width write the whole link store is cleared,
// during which no request is accepted.
// A result waiting in the output register holds the emit that follows it.
module random_dot_stereogram_row #(
    parameter int MAX_ROW_WIDTH = rdsr_pkg::DEF_MAX_ROW_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rdsr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rdsr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // pixel_depth[7:0]
    input  logic                               s_axis_tuser,  // func
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [23:0]                        m_axis_tdata,  // pixel_x[9:0], colour[17:10]
    output logic                               m_axis_tlast
);
    import rdsr_pkg::*;

    localparam int AW = $clog2(MAX_ROW_WIDTH);
    localparam int WW = $clog2(MAX_ROW_WIDTH + 1);
    localparam int IW = SEP_W + 2;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ROW_WIDTH - 1);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_SWEEP = 12'b0000_0000_0010,
        ST_SEP   = 12'b0000_0000_0100,
        ST_PAIR  = 12'b0000_0000_1000,
        ST_RD    = 12'b0000_0001_0000,
        ST_CHK   = 12'b0000_0010_0000,
        ST_FIN   = 12'b0000_0100_0000,
        ST_ERD   = 12'b0000_1000_0000,
        ST_ECHK  = 12'b0001_0000_0000,
        ST_EMOD  = 12'b0010_0000_0000,
        ST_ECOL  = 12'b0100_0000_0000,
        ST_EOUT  = 12'b1000_0000_0000
    } t_state;

    // Configuration registers.
    logic [10:0] r_far, r_depth_rng, r_width_cfg;
    logic [8:0]  r_max_level;
    logic        r_invert;

    // Control state.
    t_state      r_state;
    logic [AW-1:0] r_load_col, r_emit_col, r_x, r_ci, r_cj, r_sweep;
    logic [AW:0] r_cnt;
    logic        r_odd, r_sweep_load, r_sep_start;
    logic [31:0] r_lfsr;
    logic [7:0]  r_depth, r_col;
    logic        r_out_valid;
    logic [9:0]  r_out_x;
    logic [7:0]  r_out_c;
    logic        r_out_last;

    // Derived values.
    logic [WW-1:0] width;
    logic [8:0]    max_c;
    logic [AW-1:0] acc_load_x, acc_emit_x;
    t_sep_req      sep_req;
    logic          sep_done;
    logic signed [SEP_W-1:0] sep;
    logic          n_sep_start, n_out_valid, out_take;

    // Memory ports.
    logic          link_we;
    logic [AW-1:0] link_waddr, link_raddr;
    logic [AW:0]   link_wdata, link_rdata;
    logic          col_we;
    logic [AW-1:0] col_raddr;
    logic [7:0]    col_rdata;

    logic [AW-1:0] s_val;
    logic [AW-1:0] p_val;
    logic          accept;
    logic [31:0]   lfsr_nx;
    logic [9:0]    sum1;
    logic [8:0]    sum2;
    logic [7:0]    col_mod;
    logic signed [IW-1:0] pi, pj;
    logic [SEP_W-1:0] half;

    function automatic logic [WW-1:0] eff_width(input logic [10:0] w);
        if (w == 11'd0) begin
            return WW'(1);
        end else if (32'(w) > 32'(MAX_ROW_WIDTH)) begin
            return WW'(MAX_ROW_WIDTH);
        end else begin
            return WW'(w);
        end
    endfunction

    assign width = eff_width(r_width_cfg);
    assign max_c = (r_max_level == 9'd0) ? 9'd1 : r_max_level;

    // Column clamps at the moment of acceptance.
    always_comb begin
        acc_load_x = (WW'(r_load_col) >= width) ? '0 : r_load_col;
        acc_emit_x = (WW'(r_emit_col) >= width) ? AW'(width - 1'b1) : r_emit_col;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign sep_req = '{far_sep: r_far, depth_rng: r_depth_rng, max_c: max_c,
                       invert: r_invert, depth: r_depth};

    rdsr_sep_unit u_sep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sep_start),
        .i_req   (sep_req),
        .o_done  (sep_done),
        .o_sep   (sep)
    );

    // Pair placement: left pixel and right pixel with half-pixel rounding on odd rows.
    always_comb begin
        half = (SEP_W'(sep) + SEP_W'(sep[0] & r_odd)) >> 1;
        pi   = $signed({{(IW-AW){1'b0}}, r_x}) - $signed({2'b0, half});
        pj   = pi + IW'(sep);
    end

    // Link read answer: an unwritten link points to the column itself.
    assign s_val = link_rdata[AW] ? link_rdata[AW-1:0] : r_ci;
    assign p_val = link_rdata[AW] ? link_rdata[AW-1:0] : r_x;

    // Link memory port selection.
    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_ci;
        link_wdata = {1'b1, r_cj};
        link_raddr = (r_state == ST_ERD) ? r_x : r_ci;
        case (r_state)
            ST_SWEEP: begin
                link_we    = 1'b1;
                link_waddr = r_sweep;
                link_wdata = '0;
            end
            ST_CHK: begin
                link_we = (s_val == r_ci) || (s_val == r_cj) || (s_val > r_cj);
            end
            ST_FIN: begin
                link_we = 1'b1;
            end
            default: begin
                link_we = 1'b0;
            end
        endcase
    end

    rdsr_ram #(.WIDTH(AW + 1), .DEPTH(MAX_ROW_WIDTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    assign col_we    = out_take;
    assign col_raddr = p_val;

    rdsr_ram #(.WIDTH(8), .DEPTH(MAX_ROW_WIDTH)) u_colour_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (r_x),
        .i_wdata (r_col),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    // LFSR step and colour as the value modulo 255 by folding bytes.
    always_comb begin
        lfsr_nx = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_MASK : 32'd0);
        sum1    = 10'(r_lfsr[7:0]) + 10'(r_lfsr[15:8]) + 10'(r_lfsr[23:16])
                  + 10'(r_lfsr[31:24]);
        sum2    = 9'(sum1[7:0]) + 9'(sum1[9:8]);
        col_mod = (sum2 >= COLOUR_SPAN) ? 8'(sum2 - COLOUR_SPAN) : sum2[7:0];
    end

    // Divider start pulse and output register occupancy.
    always_comb begin
        out_take    = !i_cfg_we && (r_state == ST_EOUT) && (!r_out_valid || m_axis_tready);
        n_out_valid = out_take || (r_out_valid && !m_axis_tready);
        n_sep_start = !i_cfg_we &&
                      (((r_state == ST_IDLE) && accept && !s_axis_tuser
                        && (acc_load_x != '0))
                       || ((r_state == ST_SWEEP) && (r_sweep == LAST_ADDR) && r_sweep_load));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sep_start <= n_sep_start;
            r_out_valid <= n_out_valid;
        end
    end

    // Sequencer and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far        <= RST_FAR_SEP;
            r_depth_rng  <= RST_DEPTH_RNG;
            r_max_level  <= RST_MAX_LEVEL;
            r_invert     <= 1'b0;
            r_width_cfg  <= RST_ROW_WIDTH;
            r_lfsr       <= RST_SEED;
            r_state      <= ST_SWEEP;
            r_sweep      <= '0;
            r_sweep_load <= 1'b0;
            r_load_col   <= '0;
            r_emit_col   <= AW'(eff_width(RST_ROW_WIDTH) - 1'b1);
            r_odd        <= 1'b0;
            r_cnt        <= '0;
        end else begin
            // Configuration writes; the user must write only while the block is idle, which the block does not enforce.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FAR_SEP:   r_far       <= i_cfg_data[10:0];
                    REG_DEPTH_RNG: r_depth_rng <= i_cfg_data[10:0];
                    REG_MAX_LEVEL: r_max_level <= i_cfg_data[8:0];
                    REG_INVERT:    r_invert    <= i_cfg_data[0];
                    REG_ROW_WIDTH: begin
                        r_width_cfg  <= i_cfg_data[10:0];
                        r_load_col   <= '0;
                        r_emit_col   <= AW'(eff_width(i_cfg_data[10:0]) - 1'b1);
                        r_state      <= ST_SWEEP;
                        r_sweep      <= '0;
                        r_sweep_load <= 1'b0;
                    end
                    REG_SEED: begin
                        r_lfsr <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end else begin
                case (r_state)
                    ST_IDLE: begin
                        if (accept) begin
                            if (!s_axis_tuser) begin
                                r_x        <= acc_load_x;
                                r_depth    <= s_axis_tdata;
                                r_load_col <= (WW'(acc_load_x) + 1'b1 >= width)
                                              ? '0 : acc_load_x + 1'b1;
                                if (acc_load_x == '0) begin
                                    r_state      <= ST_SWEEP;
                                    r_sweep      <= '0;
                                    r_sweep_load <= 1'b1;
                                end else begin
                                    r_state <= ST_SEP;
                                end
                            end else begin
                                r_x     <= acc_emit_x;
                                r_state <= ST_ERD;
                            end
                        end
                    end
                    // Clear every link written bit, one entry a cycle while no configuration write is taken.
                    ST_SWEEP: begin
                        r_sweep <= r_sweep + 1'b1;
                        if (r_sweep == LAST_ADDR) begin
                            if (r_sweep_load) begin
                                r_state <= ST_SEP;
                            end else begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                    ST_SEP: begin
                        if (sep_done) begin
                            r_state <= ST_PAIR;
                        end
                    end
                    // Place the pair, and drop it when its separation is not positive or it leaves the row.
                    ST_PAIR: begin
                        if (sep > 0 && pi >= 0 && pj < $signed(IW'(width))) begin
                            r_ci    <= AW'(pi);
                            r_cj    <= AW'(pj);
                            r_cnt   <= '0;
                            r_state <= ST_RD;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                    ST_RD: begin
                        r_state <= ST_CHK;
                    end
                    // One step of the chain merge.
                    ST_CHK: begin
                        if (s_val == r_ci || s_val == r_cj) begin
                            r_state <= ST_IDLE;
                        end else begin
                            if (s_val > r_cj) begin
                                r_ci <= r_cj;
                                r_cj <= s_val;
                            end else begin
                                r_ci <= s_val;
                            end
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= ((AW+1)'(r_cnt) == (AW+1)'(MAX_ROW_WIDTH - 1))
                                       ? ST_FIN : ST_RD;
                        end
                    end
                    ST_FIN: begin
                        r_state <= ST_IDLE;
                    end
                    ST_ERD: begin
                        r_state <= ST_ECHK;
                    end
                    // Unlinked pixels take a fresh colour, linked ones copy.
                    ST_ECHK: begin
                        if (p_val == r_x) begin
                            r_lfsr  <= lfsr_nx;
                            r_state <= ST_EMOD;
                        end else begin
                            r_state <= ST_ECOL;
                        end
                    end
                    ST_EMOD: begin
                        r_col   <= col_mod;
                        r_state <= ST_EOUT;
                    end
                    ST_ECOL: begin
                        r_col   <= col_rdata;
                        r_state <= ST_EOUT;
                    end
                    // Hand the result to the output register when it is free.
                    ST_EOUT: begin
                        if (!r_out_valid || m_axis_tready) begin
                            r_out_x     <= 10'(r_x);
                            r_out_c     <= r_col;
                            r_out_last  <= (r_x == '0);
                            if (r_x == '0) begin
                                r_odd      <= ~r_odd;
                                r_load_col <= '0;
                                r_emit_col <= AW'(width - 1'b1);
                            end else begin
                                r_emit_col <= r_x - 1'b1;
                            end
                            r_state <= ST_IDLE;
                        end
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_c, r_out_x};
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== sv/rdsr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the link and colour stores; depends on nothing.
module rdsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rdsr_sep_unit.sv =====
// Separation unit: one multiply, then a restoring divide one quotient bit a cycle.
// Gives far_sep minus depth_rng * level / max_c with truncation toward zero.
// Depends on rdsr_pkg.
module rdsr_sep_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  rdsr_pkg::t_sep_req                  i_req,
    output logic                                o_done,
    output logic signed [rdsr_pkg::SEP_W-1:0]   o_sep
);
    import rdsr_pkg::*;

    localparam int NW = 21;
    localparam int CW = $clog2(NW + 1);

    logic               r_mul;
    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic signed [SEP_W-1:0] r_prod;
    logic [NW-1:0]      r_mag;
    logic [9:0]         r_rem;
    logic               r_neg;
    logic [10:0]        r_far;
    logic [8:0]         r_div;
    logic signed [SEP_W-1:0] r_sep;

    logic signed [11:0] op_level;
    logic signed [SEP_W-1:0] a_ext, b_ext;
    logic [9:0]         rem_sh;
    logic               q_bit;
    logic [9:0]         rem_nx;
    logic signed [SEP_W-1:0] q_s;

    // Operand of the multiply: level distance, or level itself when inverted.
    always_comb begin
        if (i_req.invert) begin
            op_level = $signed({4'b0, i_req.depth});
        end else begin
            op_level = $signed({3'b0, i_req.max_c}) - $signed({4'b0, i_req.depth});
        end
        a_ext = SEP_W'($signed({1'b0, i_req.depth_rng}));
        b_ext = SEP_W'(op_level);
    end

    // One restoring divide step.
    always_comb begin
        rem_sh = {r_rem[8:0], r_mag[NW-1]};
        q_bit  = (rem_sh >= {1'b0, r_div});
        rem_nx = q_bit ? (rem_sh - {1'b0, r_div}) : rem_sh;
        q_s    = $signed({{(SEP_W-NW){1'b0}}, r_mag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mul  <= 1'b1;
                r_prod <= a_ext * b_ext;
                r_far  <= i_req.far_sep;
                r_div  <= i_req.max_c;
            end else if (r_mul) begin
                // Take the magnitude and start the divide.
                r_mul  <= 1'b0;
                r_busy <= 1'b1;
                r_neg  <= r_prod[SEP_W-1];
                r_mag  <= r_prod[SEP_W-1] ? NW'(-r_prod) : NW'(r_prod);
                r_rem  <= '0;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_sep  <= $signed({{(SEP_W-11){1'b0}}, r_far})
                              - (r_neg ? -q_s : q_s);
                end else begin
                    r_rem <= rem_nx;
                    r_mag <= {r_mag[NW-2:0], q_bit};
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_sep  = r_sep;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for random_dot_stereogram_row: directed table then random rows of loads and emits,
// every colour request checked against a behavioural predictor of the row engine.
// Depends on rdsr_pkg and the RTL of random_dot_stereogram_row.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rdsr_pkg::*;

    localparam int WIDTH_MAX  = 1024;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 60;
    localparam bit FN_LOAD    = 1'b0;
    localparam bit FN_EMIT    = 1'b1;

    typedef struct {
        logic [9:0] x;
        logic [7:0] colour;
        logic       done;
    } t_pixel;

    typedef struct {
        bit         fn;
        logic [7:0] depth;
        bit         typed;
        int         ex;
        bit         elast;
    } t_row_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // pixel_depth[7:0]
    logic        s_axis_tuser = 1'b0; // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // pixel_x[9:0], colour[17:10]
    logic        m_axis_tlast;

    random_dot_stereogram_row dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of registers and row state.
    int unsigned far_sep_r, depth_rng_r, max_lvl_r, invert_r, width_r, seed_r;
    int          partner [WIDTH_MAX];
    bit          partner_ok [WIDTH_MAX];
    logic [7:0]  colour_mem [WIDTH_MAX];
    int          load_col, emit_col;
    bit          odd_row;
    logic [31:0] lfsr;

    t_pixel pixel_q [$];
    int     mismatches = 0;
    bit     idle_en = 1'b1;
    bit     long_hold = 1'b0;
    int     items_sent = 0;

    function automatic int row_w();
        if (width_r == 0) return 1;
        if (width_r > WIDTH_MAX) return WIDTH_MAX;
        return int'(width_r);
    endfunction

    function automatic int link_of(int k);
        if (k < 0 || k >= WIDTH_MAX) return k;
        return partner_ok[k] ? partner[k] : k;
    endfunction

    function automatic void put_link(int k, int v);
        if (k < 0 || k >= WIDTH_MAX || v < 0) return;
        partner[k] = v;
        partner_ok[k] = 1'b1;
    endfunction

    function automatic void restart_row();
        foreach (partner_ok[k]) partner_ok[k] = 1'b0;
        load_col = 0;
        emit_col = row_w() - 1;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        case (idx)
            REG_FAR_SEP:   far_sep_r = v[10:0];
            REG_DEPTH_RNG: depth_rng_r = v[10:0];
            REG_MAX_LEVEL: max_lvl_r = v[8:0];
            REG_INVERT:    invert_r = v[0];
            REG_ROW_WIDTH: begin
                width_r = v[10:0];
                restart_row();
            end
            REG_SEED: begin
                seed_r = v;
                lfsr = (v == 0) ? 32'd1 : v;
            end
            default: ;
        endcase
    endfunction

    // Place one depth pixel's pair and merge it into the rightward chain.
    function automatic void predict_load(int d);
        int w, x, maxc, num, sep, i, j, s;
        w = row_w();
        x = load_col;
        maxc = (max_lvl_r == 0) ? 1 : int'(max_lvl_r);
        if (x >= w) x = 0;
        if (x == 0) foreach (partner_ok[k]) partner_ok[k] = 1'b0;
        num = invert_r ? int'(depth_rng_r) * d : int'(depth_rng_r) * (maxc - d);
        sep = int'(far_sep_r) - num / maxc;
        if (sep > 0) begin
            i = x - (sep + (sep & int'(odd_row))) / 2;
            j = i + sep;
            if (i >= 0 && j < w) begin
                for (int n = 0; n < WIDTH_MAX; n++) begin
                    s = link_of(i);
                    if (s == i || s == j) break;
                    if (s > j) begin
                        put_link(i, j);
                        i = j;
                        j = s;
                    end else begin
                        i = s;
                    end
                end
                put_link(i, j);
            end
        end
        load_col = (x + 1 >= w) ? 0 : x + 1;
    endfunction

    // Colour the next pixel from the right, fresh or copied from its partner.
    function automatic t_pixel predict_emit();
        t_pixel r;
        int w, x, p;
        logic [7:0] c;
        w = row_w();
        x = emit_col;
        if (x >= w) x = w - 1;
        p = link_of(x);
        if (p == x || p < 0 || p >= WIDTH_MAX) begin
            lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
            c = 8'(lfsr % 255);
        end else begin
            c = colour_mem[p];
        end
        colour_mem[x] = c;
        r.x = x[9:0];
        r.colour = c;
        r.done = (x == 0);
        if (x == 0) begin
            odd_row = ~odd_row;
            load_col = 0;
            emit_col = w - 1;
        end else begin
            emit_col = x - 1;
        end
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        apply_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Withdraw the request and wait for the block to drain before touching the registers.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Offer one request and predict its outcome once it is taken.
    task automatic send_item(t_row_item it);
        t_pixel p;
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = it.fn;
        s_axis_tdata = it.depth;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (it.fn == FN_LOAD) begin
            predict_load(it.depth);
        end else begin
            p = predict_emit();
            if (it.typed) begin
                p.x = it.ex[9:0];
                p.done = it.elast;
            end
            pixel_q.push_back(p);
        end
    endtask

    task automatic send_row(int nloads, bit smooth);
        t_row_item it;
        int d;
        d = $urandom_range(0, 255);
        it.typed = 1'b0;
        for (int k = 0; k < nloads; k++) begin
            if (smooth) d = (d + $urandom_range(0, 8) + 252) & 8'hff;
            else d = $urandom_range(0, 255);
            it.fn = FN_LOAD;
            it.depth = d[7:0];
            send_item(it);
        end
        for (int k = 0; k < row_w(); k++) begin
            it.fn = FN_EMIT;
            it.depth = $urandom_range(0, 255);
            send_item(it);
        end
    endtask

    task automatic set_all(int far, int rng, int lvl, int inv, int w, logic [31:0] seed);
        drain();
        write_reg(REG_FAR_SEP, far);
        write_reg(REG_DEPTH_RNG, rng);
        write_reg(REG_MAX_LEVEL, lvl);
        write_reg(REG_INVERT, inv);
        write_reg(REG_ROW_WIDTH, w);
        write_reg(REG_SEED, seed);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel x=%0d colour=%0d", m_axis_tdata[9:0],
                             m_axis_tdata[17:10]);
            end else begin
                e = pixel_q.pop_front();
                if (e.x !== m_axis_tdata[9:0] || e.colour !== m_axis_tdata[17:10] ||
                    e.done !== m_axis_tlast) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: exp x=%0d c=%0d last=%0d, got x=%0d c=%0d last=%0d",
                                 e.x, e.colour, e.done, m_axis_tdata[9:0],
                                 m_axis_tdata[17:10], m_axis_tlast);
                end
            end
        end
    end

    // Receiver stalls: short random bursts, and one long hold-off on request.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                m_axis_tready = 1'b0;
                repeat (300) @(negedge i_clk);
                long_hold = 1'b0;
            end
            if (stall > 0 && idle_en) begin
                stall--;
                m_axis_tready = 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(0, 5);
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Watchdog on cycles without any handshake.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("random_dot_stereogram_row regression: fail");
                $finish;
            end
        end
    end

    t_row_item dir_tab [$];

    initial begin
        t_row_item it;
        // Reset state of the predictor.
        far_sep_r = RST_FAR_SEP;
        depth_rng_r = RST_DEPTH_RNG;
        max_lvl_r = RST_MAX_LEVEL;
        invert_r = 0;
        width_r = RST_ROW_WIDTH;
        seed_r = RST_SEED;
        lfsr = RST_SEED;
        odd_row = 1'b0;
        foreach (colour_mem[k]) colour_mem[k] = '0;
        foreach (partner[k]) partner[k] = 0;
        restart_row();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: four-pixel rows with extreme depths, short and overlong loads.
        write_reg(REG_ROW_WIDTH, 4);
        write_reg(REG_FAR_SEP, 2);
        write_reg(REG_DEPTH_RNG, 2);
        foreach (dir_tab[k]) ;
        dir_tab = '{
            '{FN_LOAD, 8'd0, 0, 0, 0}, '{FN_LOAD, 8'd255, 0, 0, 0},
            '{FN_LOAD, 8'd128, 0, 0, 0}, '{FN_LOAD, 8'd255, 0, 0, 0},
            '{FN_EMIT, 8'd0, 1, 3, 0}, '{FN_EMIT, 8'd0, 1, 2, 0},
            '{FN_EMIT, 8'd0, 1, 1, 0}, '{FN_EMIT, 8'd0, 1, 0, 1},
            '{FN_LOAD, 8'd255, 0, 0, 0}, '{FN_LOAD, 8'd0, 0, 0, 0},
            '{FN_EMIT, 8'd255, 1, 3, 0}, '{FN_EMIT, 8'd0, 1, 2, 0},
            '{FN_EMIT, 8'd0, 1, 1, 0}, '{FN_EMIT, 8'd0, 1, 0, 1},
            '{FN_LOAD, 8'd1, 0, 0, 0}, '{FN_LOAD, 8'd254, 0, 0, 0},
            '{FN_LOAD, 8'd170, 0, 0, 0}, '{FN_LOAD, 8'd85, 0, 0, 0},
            '{FN_LOAD, 8'd255, 0, 0, 0}, '{FN_LOAD, 8'd0, 0, 0, 0},
            '{FN_EMIT, 8'd0, 1, 3, 0}, '{FN_EMIT, 8'd0, 1, 2, 0},
            '{FN_EMIT, 8'd0, 1, 1, 0}, '{FN_EMIT, 8'd0, 1, 0, 1}};
        foreach (dir_tab[k]) send_item(dir_tab[k]);

        // Extreme settings: zero scale and seed, width zero, oversized width.
        set_all(0, 0, 0, 0, 0, 0);
        send_row(3, 0);
        set_all(1024, 1024, 1, 1, 1, 32'hffff_ffff);
        send_row(2, 0);
        set_all(20, 1024, 511, 0, 16, 32'h1234_5678);
        send_row(16, 1);
        set_all(40, 30, 256, 0, 2047, 32'hdead_beef);
        send_row(24, 1);

        // Receiver holds off while rows keep coming.
        set_all(12, 8, 256, 0, 24, 32'h0bad_cafe);
        long_hold = 1'b1;
        send_row(24, 1);
        send_row(24, 0);

        // Random settings, mostly complete rows with smooth surfaces.
        while (items_sent < 1300) begin
            set_all($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 256),
                    $urandom_range(0, 1), $urandom_range(4, 48), $urandom());
            repeat ($urandom_range(2, 4)) begin
                if (items_sent > 1260) idle_en = 1'b0;
                if ($urandom_range(0, 4) == 0) send_row($urandom_range(0, row_w() + 3), 0);
                else send_row(row_w(), $urandom_range(0, 3) != 0);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        drain();
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("random_dot_stereogram_row regression: pass");
        else
            $display("random_dot_stereogram_row regression: fail");
        $finish;
    end
endmodule
